// File: rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine: operation kinds
// and result status codes.
// ----------------------------------------------------------------------------
package ple_pkg;

    typedef logic [2:0]  t_kind;
    typedef logic [1:0]  t_status;
    typedef logic [31:0] t_word;

    localparam t_kind K_INSERT = 3'd0;
    localparam t_kind K_DELETE = 3'd1;
    localparam t_kind K_LOCATE = 3'd2;
    localparam t_kind K_DUMP   = 3'd3;
    localparam t_kind K_CLEAR  = 3'd4;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_BAD_POS = 2'd1;
    localparam t_status ST_FULL    = 2'd2;

endpackage

// File: rtl/core/ple_in_if.sv
// ----------------------------------------------------------------------------
// ple_in_if
// Request channel of the positional list engine: valid/ready plus one
// operation (kind, position, value).
// ----------------------------------------------------------------------------
interface ple_in_if;
    logic                valid;
    logic                ready;
    ple_pkg::t_kind      kind;
    logic [7:0]          position;
    logic signed [31:0]  item_value;

    modport source (output valid, output kind, output position, output item_value,
                    input ready);
    modport sink   (input valid, input kind, input position, input item_value,
                    output ready);
endinterface

// File: rtl/core/ple_out_if.sv
// ----------------------------------------------------------------------------
// ple_out_if
// Result channel of the positional list engine: valid/ready plus one
// result record.
// ----------------------------------------------------------------------------
interface ple_out_if;
    logic                valid;
    logic                ready;
    ple_pkg::t_status    status;
    logic signed [31:0]  value_out;
    logic [7:0]          found_index;
    logic [7:0]          list_length;
    logic                last;

    modport source (output valid, output status, output value_out, output found_index,
                    output list_length, output last, input ready);
    modport sink   (input valid, input status, input value_out, input found_index,
                    input list_length, input last, output ready);
endinterface

// File: rtl/core/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Bounded ordered list of 32-bit words kept in one RAM. Insert and delete
// move the tail one word per cycle through the RAM; locate and dump scan it.
//
//   channel   dir   handshake        payload
//   i_in      in    valid / ready    kind, position, item_value
//   o_out     out   valid / ready    status, value_out, found_index,
//                                    list_length, last
//
// One operation at a time; i_in.ready is high only when the sequencer is idle.
// Insert and delete move only the words behind the position (an append
// moves none), locate stops at its first match, dump reads once per element.
// Results wait in an output register, so the next operation is taken while
// one waits; a stalled output holds up dump and the final result only.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine_top #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ple_in_if.sink     i_in,
    ple_out_if.source  o_out
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (((AW + 1) > 8) ? (AW + 1) : 8) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UP    = 3'd1;
    localparam logic [2:0] S_PUT   = 3'd2;
    localparam logic [2:0] S_DEL   = 3'd3;
    localparam logic [2:0] S_LOC   = 3'd4;
    localparam logic [2:0] S_DUMP  = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    // control
    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_rvld;
    logic              r_hit;
    logic              r_out_valid;

    // operation context
    ple_pkg::t_kind    r_kind;
    ple_pkg::t_status  r_status, n_status;
    logic [AW-1:0]     r_tgt;
    logic [AW-1:0]     r_end;
    logic [AW-1:0]     r_ra_d;
    ple_pkg::t_word    r_val;
    ple_pkg::t_word    r_value;
    logic [7:0]        r_found;

    // output register
    ple_pkg::t_status  r_out_status;
    ple_pkg::t_word    r_out_value;
    logic [7:0]        r_out_found;
    logic [7:0]        r_out_len;
    logic              r_out_last;

    logic              w_acc;
    logic              w_out_free;
    logic              w_rd;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    ple_pkg::t_word    w_wdata;
    ple_pkg::t_word    w_rdata;
    logic              w_match;
    logic              w_ld_fin;
    logic              w_ld_dump;
    logic              w_capture;
    logic [XW-1:0]     w_pos_x;
    logic [XW-1:0]     w_n_x;
    logic [XW-1:0]     w_ra_inc;
    logic [XW-1:0]     w_len_x;
    logic [AW-1:0]     w_tgt_acc;
    logic [AW-1:0]     w_end_acc;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_pos_x   = XW'(i_in.position);
    assign w_n_x     = XW'(r_count);
    assign w_tgt_acc = AW'(w_pos_x - XW'(1));
    assign w_end_acc = AW'(w_n_x - XW'(1));
    assign w_ra_inc  = XW'(r_ra_d) + XW'(1);
    assign w_len_x   = XW'(r_count);

    assign w_match   = r_rvld && (r_kind == ple_pkg::K_LOCATE) && !r_hit
                       && (w_rdata == r_val);
    assign w_capture = r_rvld && (r_kind == ple_pkg::K_DELETE) && (r_ra_d == r_tgt);
    assign w_ld_dump = r_rvld && (r_kind == ple_pkg::K_DUMP);

    // Write port: moves of the previous read take priority over the final store.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_tgt;
        w_wdata = r_val;
        if (r_rvld && (r_kind == ple_pkg::K_INSERT)) begin
            w_we    = 1'b1;
            w_waddr = r_ra_d + AW'(1);
            w_wdata = w_rdata;
        end else if (r_rvld && (r_kind == ple_pkg::K_DELETE) && (r_ra_d != r_tgt)) begin
            w_we    = 1'b1;
            w_waddr = r_ra_d - AW'(1);
            w_wdata = w_rdata;
        end else if (r_state == S_PUT) begin
            w_we    = 1'b1;
        end
    end

    ple_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_count  = r_count;
        n_status = r_status;
        w_rd     = 1'b0;
        w_ld_fin = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_status = ple_pkg::ST_OK;
                    n_state  = S_FIN;
                    unique case (i_in.kind)
                        ple_pkg::K_INSERT: begin
                            if (i_in.position == 8'd0 || w_pos_x > w_n_x + XW'(1)) begin
                                n_status = ple_pkg::ST_BAD_POS;
                            end else if (w_n_x == XW'(CAPACITY)) begin
                                n_status = ple_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                                if (w_pos_x <= w_n_x) begin
                                    n_idx   = w_end_acc;
                                    n_state = S_UP;
                                end else begin
                                    n_state = S_PUT;
                                end
                            end
                        end
                        ple_pkg::K_DELETE: begin
                            if (i_in.position == 8'd0 || w_pos_x > w_n_x) begin
                                n_status = ple_pkg::ST_BAD_POS;
                            end else begin
                                n_count = r_count - CW'(1);
                                n_idx   = w_tgt_acc;
                                n_state = S_DEL;
                            end
                        end
                        ple_pkg::K_LOCATE: begin
                            if (r_count != '0) begin
                                n_idx   = '0;
                                n_state = S_LOC;
                            end
                        end
                        ple_pkg::K_DUMP: begin
                            if (r_count != '0) begin
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        ple_pkg::K_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_UP: begin
                w_rd = 1'b1;
                if (r_idx == r_tgt) begin
                    n_state = S_PUT;
                end else begin
                    n_idx = r_idx - AW'(1);
                end
            end
            S_PUT: begin
                // the store itself happens once the last move has drained
                if (!r_rvld) begin
                    n_state = S_FIN;
                end
            end
            S_DEL: begin
                w_rd = 1'b1;
                if (r_idx == r_end) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_LOC: begin
                if (w_match) begin
                    n_state = S_DRAIN;
                end else begin
                    w_rd = 1'b1;
                    if (r_idx == r_end) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            S_DUMP: begin
                // one read in flight at most, and only when the output has room
                if (!r_rvld && w_out_free) begin
                    w_rd = 1'b1;
                    if (r_idx == r_end) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            S_DRAIN: begin
                if (!r_rvld) begin
                    n_state = (r_kind == ple_pkg::K_DUMP) ? S_IDLE : S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    w_ld_fin = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rvld      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rvld  <= w_rd;
            if (w_acc) begin
                r_hit <= 1'b0;
            end else if (w_match) begin
                r_hit <= 1'b1;
            end
            if (w_ld_fin || w_ld_dump) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_status <= n_status;
        r_ra_d   <= r_idx;
        if (w_acc) begin
            r_kind  <= i_in.kind;
            r_val   <= i_in.item_value;
            r_tgt   <= w_tgt_acc;
            r_end   <= w_end_acc;
            r_value <= '0;
            r_found <= '0;
        end else begin
            if (w_capture) begin
                r_value <= w_rdata;
            end
            if (w_match) begin
                r_found <= w_ra_inc[7:0];
            end
        end
        if (w_ld_fin) begin
            r_out_status <= r_status;
            r_out_value  <= r_value;
            r_out_found  <= r_found;
            r_out_len    <= w_len_x[7:0];
            r_out_last   <= 1'b1;
        end else if (w_ld_dump) begin
            r_out_status <= ple_pkg::ST_OK;
            r_out_value  <= w_rdata;
            r_out_found  <= '0;
            r_out_len    <= w_len_x[7:0];
            r_out_last   <= (r_ra_d == r_end);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.value_out   = r_out_value;
    assign o_out.found_index = r_out_found;
    assign o_out.list_length = r_out_len;
    assign o_out.last        = r_out_last;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rvld)
        else $error("RAM read still in flight while idle");

    a_partial_is_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_kind == ple_pkg::K_DUMP))
        else $error("non-final result outside a dump");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_rd) |-> (w_waddr != r_idx))
        else $error("read and write hit the same entry");
`endif

endmodule
